/* sv/lrupr_pkg.sv */
package lrupr_pkg;

    localparam int PAGE_W      = 16;
    localparam int FRAME_IDX_W = 3;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 4;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RESET = 4'd8;
    localparam logic [APB_AW-1:0] REG_FRAMES_IN_USE   = 3'd0;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

/* sv/lrupr_frame_store.sv */
module lrupr_frame_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                        clk,
    input  lrupr_pkg::store_ctl_t       ctl,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lrupr_pkg::PAGE_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [lrupr_pkg::PAGE_W-1:0] rd_data
);

    logic [lrupr_pkg::PAGE_W-1:0] mem [DEPTH];
    logic [lrupr_pkg::PAGE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lru_page_replacement_top.sv */
// LRU page replacement unit.
// A request carries one page number on page_number, qualified by req_valid and
// accepted when req_valid is high and req_stall is low. Each request gives one
// result: hit, frame_index, evicted_valid, evicted_page and fault_count,
// qualified by res_valid and taken when res_stall is low.
// The unit scans the active frames one per cycle through a single read port of
// the page memory, finding the hit, the first empty frame and the oldest frame
// in the same pass. After the scan come the tail and update states, and the
// result register is loaded when the update commits; req_stall is high in the
// scan, tail and update states, so a new request waits until the last is done.
// If the result register is still held by a stalled receiver, the update cycle
// waits, so no result is lost or repeated. The user must write frames_in_use
// over the APB port at address 0 only while the unit is idle; the unit itself
// does not enforce this. Reset clears all valid bits, recency ranks and the
// fault count and sets frames_in_use to 8; page contents need no clearing.
module lru_page_replacement_top #(
    parameter int FRAMES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lrupr_pkg::APB_AW-1:0]      paddr,
    input  logic [lrupr_pkg::APB_DW-1:0]      pwdata,
    output logic [lrupr_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]      page_number,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index,
    output logic                              evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]      evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]     fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW    = ($clog2(FRAMES + 1) > lrupr_pkg::CFG_W) ?
                           $clog2(FRAMES + 1) : lrupr_pkg::CFG_W;
    localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_UPDATE
    } state_t;

    state_t                          state_reg;
    logic [lrupr_pkg::CFG_W-1:0]     frames_in_use_reg;
    logic [lrupr_pkg::PAGE_W-1:0]    page_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                cmp_idx_reg;
    logic                            cmp_vld_reg;
    logic                            hit_found_reg;
    logic [IDX_W-1:0]                hit_slot_reg;
    logic [IDX_W-1:0]                hit_rank_reg;
    logic                            empty_found_reg;
    logic [IDX_W-1:0]                empty_slot_reg;
    logic [IDX_W-1:0]                vic_slot_reg;
    logic [IDX_W-1:0]                vic_rank_reg;
    logic [lrupr_pkg::PAGE_W-1:0]    vic_page_reg;
    logic [FRAMES-1:0]               valid_reg;
    logic [IDX_W-1:0]                rank_reg [FRAMES];
    logic [lrupr_pkg::COUNT_W-1:0]   faults_reg;
    logic                            res_valid_reg;
    logic                            hit_out_reg;
    logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index_reg;
    logic                            evicted_valid_reg;
    logic [lrupr_pkg::PAGE_W-1:0]    evicted_page_reg;

    logic [CW-1:0]                   cfg_w;
    logic [IDX_W-1:0]                n_last;
    logic [lrupr_pkg::PAGE_W-1:0]    rd_page;
    lrupr_pkg::store_ctl_t           store_ctl;
    logic                            commit;
    logic [IDX_W-1:0]                slot;
    logic [FRAMES-1:0]               valid_next;
    logic [IDX_W-1:0]                rank_next [FRAMES];
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr == lrupr_pkg::REG_FRAMES_IN_USE);
    assign prdata = (paddr == lrupr_pkg::REG_FRAMES_IN_USE) ?
                    lrupr_pkg::APB_DW'(frames_in_use_reg) : '0;

    // A count of zero acts as one; a count above FRAMES acts as FRAMES.
    assign cfg_w = CW'(frames_in_use_reg);
    always_comb
    begin
        priority if (cfg_w == '0)
        begin
            n_last = '0;
        end
        else if (cfg_w > CW'(FRAMES))
        begin
            n_last = IDX_W'(FRAMES - 1);
        end
        else
        begin
            n_last = IDX_W'(cfg_w - CW'(1));
        end
    end

    assign commit = (state_reg == ST_UPDATE) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        priority if (hit_found_reg)
        begin
            slot = hit_slot_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_slot_reg;
        end
        else
        begin
            slot = vic_slot_reg;
        end
    end

    assign store_ctl.rd_en = (state_reg == ST_SCAN);
    assign store_ctl.wr_en = commit && !hit_found_reg;

    lrupr_frame_store #(
        .DEPTH (FRAMES),
        .AW    (IDX_W)
    ) u_frame_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_addr (slot),
        .wr_data (page_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_page)
    );

    // A hit ages frames younger than the hit; a miss ages all other valid frames.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if ((IDX_W'(i) <= n_last) && (IDX_W'(i) != slot) && valid_reg[i] &&
                (!hit_found_reg || (rank_reg[i] < hit_rank_reg)) &&
                (rank_reg[i] < RANK_MAX))
            begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end
        end
        rank_next[slot]  = '0;
        valid_next[slot] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= lrupr_pkg::FRAMES_IN_USE_RESET;
            idx_reg           <= '0;
            cmp_idx_reg       <= '0;
            cmp_vld_reg       <= 1'b0;
            hit_found_reg     <= 1'b0;
            hit_slot_reg      <= '0;
            hit_rank_reg      <= '0;
            empty_found_reg   <= 1'b0;
            empty_slot_reg    <= '0;
            vic_slot_reg      <= '0;
            vic_rank_reg      <= '0;
            valid_reg         <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
            faults_reg        <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                frames_in_use_reg <= pwdata[lrupr_pkg::CFG_W-1:0];
            end

            if (res_valid_reg && !res_stall && !commit)
            begin
                res_valid_reg <= 1'b0;
            end

            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= idx_reg;

            if (cmp_vld_reg)
            begin
                if (!hit_found_reg && valid_reg[cmp_idx_reg] && (rd_page == page_reg))
                begin
                    hit_found_reg <= 1'b1;
                    hit_slot_reg  <= cmp_idx_reg;
                    hit_rank_reg  <= rank_reg[cmp_idx_reg];
                end
                if (!empty_found_reg && !valid_reg[cmp_idx_reg])
                begin
                    empty_found_reg <= 1'b1;
                    empty_slot_reg  <= cmp_idx_reg;
                end
                if ((cmp_idx_reg == '0) || (rank_reg[cmp_idx_reg] > vic_rank_reg))
                begin
                    vic_slot_reg <= cmp_idx_reg;
                    vic_rank_reg <= rank_reg[cmp_idx_reg];
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        idx_reg         <= '0;
                        hit_found_reg   <= 1'b0;
                        empty_found_reg <= 1'b0;
                        state_reg       <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == n_last)
                    begin
                        state_reg <= ST_TAIL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_TAIL:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (commit)
                    begin
                        valid_reg <= valid_next;
                        for (int i = 0; i < FRAMES; i++)
                        begin
                            rank_reg[i] <= rank_next[i];
                        end
                        if (!hit_found_reg && (faults_reg != '1))
                        begin
                            faults_reg <= faults_reg + lrupr_pkg::COUNT_W'(1);
                        end
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req_valid)
        begin
            page_reg <= page_number;
        end
        if (cmp_vld_reg && ((cmp_idx_reg == '0) || (rank_reg[cmp_idx_reg] > vic_rank_reg)))
        begin
            vic_page_reg <= rd_page;
        end
        if (commit)
        begin
            hit_out_reg       <= hit_found_reg;
            frame_index_reg   <= lrupr_pkg::FRAME_IDX_W'(slot);
            evicted_valid_reg <= !hit_found_reg && !empty_found_reg;
            evicted_page_reg  <= (!hit_found_reg && !empty_found_reg) ? vic_page_reg : '0;
        end
    end

    assign req_stall     = (state_reg != ST_IDLE);
    assign res_valid     = res_valid_reg;
    assign hit           = hit_out_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = faults_reg;

`ifndef SYNTHESIS
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result appeared without an update cycle");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && hit_out_reg) |-> !evicted_valid_reg)
        else $error("hit reported together with an eviction");

    a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPDATE) |=> (faults_reg == $past(faults_reg)))
        else $error("fault count changed outside an update cycle");
`endif

endmodule
